// ===== sv/qpe_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package qpe_pkg;

   // Queue depth between classifier and emitter
   localparam int QPE_QUEUE_DEPTH = 4;

   // Soft break length after reset
   localparam logic [6:0] QPE_LIMIT_RESET = 7'd72;

   // Character codes
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_SP    = 8'h20;
   localparam logic [7:0] CH_FIRST = 8'h21;
   localparam logic [7:0] CH_DOT   = 8'h2E;
   localparam logic [7:0] CH_EQ    = 8'h3D;
   localparam logic [7:0] CH_LAST  = 8'h7E;

   // How one byte is to be written out
   typedef enum logic [1:0] {
      KIND_LF,
      KIND_LIT,
      KIND_ESC
   } kind_type;

   // One queued command: up to two bytes to encode plus an optional flush
   typedef struct packed {
      logic [7:0] a_byte;
      kind_type   a_kind;
      logic       b_valid;
      logic [7:0] b_byte;
      kind_type   b_kind;
      logic       fin;
   } cmd_type;

   // Emitter states; each state but ST_IDLE outputs one byte
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DOT,
      ST_LIT,
      ST_EQ,
      ST_HI,
      ST_LO,
      ST_SBEQ,
      ST_CR,
      ST_LF
   } st_type;

   typedef enum logic [1:0] {
      PH_A,
      PH_B,
      PH_FLUSH
   } phase_type;

   // ws_ok: tab and space may pass literally (next byte is not LF)
   function automatic kind_type classify(input logic [7:0] d, input logic ws_ok);
      kind_type k;
      if (d == CH_LF) begin
         k = KIND_LF;
      end else if ((d >= CH_FIRST && d <= CH_LAST && d != CH_EQ) ||
                   ((d == CH_TAB || d == CH_SP) && ws_ok)) begin
         k = KIND_LIT;
      end else begin
         k = KIND_ESC;
      end
      return k;
   endfunction

   // Upper-case hex digit
   function automatic logic [7:0] hex_char(input logic [3:0] n);
      logic [7:0] c;
      if (n < 4'd10) begin
         c = 8'h30 + {4'h0, n};
      end else begin
         c = 8'h37 + {4'h0, n};
      end
      return c;
   endfunction

   // First emitter state for a byte, given the current line length
   function automatic st_type start_state(input kind_type k, input logic [7:0] d,
                                          input logic [6:0] line);
      st_type s;
      unique case (k)
         KIND_LF:  s = ST_CR;
         KIND_LIT: s = (line == 7'd0 && d == CH_DOT) ? ST_DOT : ST_LIT;
         KIND_ESC: s = ST_EQ;
         default:  s = ST_EQ;
      endcase
      return s;
   endfunction

endpackage

`default_nettype wire

// ===== sv/qpe_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none

module qpe_fifo #(
   parameter int Depth = qpe_pkg::QPE_QUEUE_DEPTH
) (
   input  wire              clock,
   input  wire              reset,
   input  wire              push,
   input  qpe_pkg::cmd_type push_cmd,
   output logic             full,
   input  wire              pop,
   output logic             head_valid,
   output qpe_pkg::cmd_type head_cmd
);
   import qpe_pkg::*;

   localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW = $clog2(Depth + 1);

   cmd_type           slot_ff [Depth];
   logic [PtrW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]   count_ff,  count_in;

   assign full       = (count_ff == CntW'(Depth));
   assign head_valid = (count_ff != '0);
   assign head_cmd   = slot_ff[rd_ptr_ff];

   // Pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(Depth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Slot storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (!full || pop))
      else $error("queue written while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> head_valid)
      else $error("queue read while empty");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CntW'(Depth))
      else $error("queue fill count out of range");

endmodule

`default_nettype wire

// ===== sv/qpe_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module qpe_front (
   input  wire              clock,
   input  wire              reset,
   input  wire              req_tvalid,
   output logic             req_tready,
   input  wire  [7:0]       req_tdata,
   input  wire              req_tlast,
   input  wire              q_full,
   output logic             q_push,
   output qpe_pkg::cmd_type q_cmd
);
   import qpe_pkg::*;

   logic [7:0] held_byte_ff;
   logic       held_valid_ff, held_valid_in;
   logic       accept;
   logic       crlf_pair;

   assign req_tready = !q_full;
   assign accept     = req_tvalid && req_tready;
   assign crlf_pair  = held_valid_ff && (held_byte_ff == CH_CR) && (req_tdata == CH_LF);

   // An item causes output once something is held or it ends the message
   assign q_push = accept && (held_valid_ff || req_tlast);

   // Classify the held byte (with lookahead) and, on the last byte, the new one
   always_comb begin
      q_cmd.fin     = req_tlast;
      q_cmd.b_valid = 1'b0;
      q_cmd.b_byte  = req_tdata;
      q_cmd.b_kind  = classify(req_tdata, 1'b1);
      if (crlf_pair) begin
         q_cmd.a_byte = CH_LF;
         q_cmd.a_kind = KIND_LF;
      end else if (held_valid_ff) begin
         q_cmd.a_byte  = held_byte_ff;
         q_cmd.a_kind  = classify(held_byte_ff, req_tdata != CH_LF);
         q_cmd.b_valid = req_tlast;
      end else begin
         q_cmd.a_byte = req_tdata;
         q_cmd.a_kind = classify(req_tdata, 1'b1);
      end
   end

   // Lookahead holding register
   assign held_valid_in = accept ? (!req_tlast && !crlf_pair) : held_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         held_valid_ff <= 1'b0;
      end else begin
         held_valid_ff <= held_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         held_byte_ff <= req_tdata;
      end
   end

endmodule

`default_nettype wire

// ===== sv/qpe_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module qpe_back (
   input  wire              clock,
   input  wire              reset,
   input  wire  [6:0]       limit,
   input  wire              q_valid,
   input  qpe_pkg::cmd_type q_head,
   output logic             q_pop,
   output logic             rsp_tvalid,
   input  wire              rsp_tready,
   output logic [7:0]       rsp_tdata,
   output logic             rsp_tlast
);
   import qpe_pkg::*;

   st_type     state_ff, state_in;
   phase_type  phase_ff, phase_in;
   cmd_type    cmd_ff,   cmd_in;
   logic [6:0] line_ff,  line_in;
   logic       rsp_valid_ff;
   logic [7:0] rsp_data_ff;
   logic       rsp_last_ff;
   logic       emit;
   logic       step_done;
   logic [7:0] cur_byte;
   logic [7:0] out_byte;

   assign emit     = (state_ff != ST_IDLE) && (!rsp_valid_ff || rsp_tready);
   assign cur_byte = (phase_ff == PH_B) ? cmd_ff.b_byte : cmd_ff.a_byte;

   // Next state: sequence bytes, track line length, load next command
   always_comb begin
      logic [7:0] len;
      logic       op_end;
      len       = {1'b0, line_ff} + 8'd1;
      op_end    = 1'b0;
      step_done = 1'b0;
      q_pop     = 1'b0;
      state_in  = state_ff;
      phase_in  = phase_ff;
      cmd_in    = cmd_ff;
      line_in   = line_ff;
      if (emit) begin
         unique case (state_ff)
            ST_DOT: state_in = ST_LIT;
            ST_LIT, ST_LO: begin
               len = {1'b0, line_ff} + ((state_ff == ST_LO) ? 8'd3 : 8'd1);
               if (len >= {1'b0, limit}) begin
                  state_in = ST_SBEQ;
                  line_in  = 7'd0;
               end else begin
                  line_in = len[6:0];
                  op_end  = 1'b1;
               end
            end
            ST_EQ:   state_in = ST_HI;
            ST_HI:   state_in = ST_LO;
            ST_SBEQ: state_in = ST_CR;
            ST_CR:   state_in = ST_LF;
            ST_LF: begin
               line_in = 7'd0;
               op_end  = 1'b1;
            end
            default: state_in = ST_IDLE;
         endcase
         if (op_end) begin
            priority if (phase_ff == PH_A && cmd_ff.b_valid) begin
               phase_in = PH_B;
               state_in = start_state(cmd_ff.b_kind, cmd_ff.b_byte, line_in);
            end else if (phase_ff != PH_FLUSH && cmd_ff.fin && line_in != 7'd0) begin
               phase_in = PH_FLUSH;
               state_in = ST_CR;
            end else begin
               step_done = 1'b1;
               state_in  = ST_IDLE;
            end
         end
      end
      if ((state_ff == ST_IDLE || step_done) && q_valid) begin
         q_pop    = 1'b1;
         cmd_in   = q_head;
         phase_in = PH_A;
         state_in = start_state(q_head.a_kind, q_head.a_byte, line_in);
      end
   end

   // Output byte for the current state
   always_comb begin
      unique case (state_ff)
         ST_DOT:  out_byte = CH_DOT;
         ST_LIT:  out_byte = cur_byte;
         ST_EQ:   out_byte = CH_EQ;
         ST_HI:   out_byte = hex_char(cur_byte[7:4]);
         ST_LO:   out_byte = hex_char(cur_byte[3:0]);
         ST_SBEQ: out_byte = CH_EQ;
         ST_CR:   out_byte = CH_CR;
         ST_LF:   out_byte = CH_LF;
         default: out_byte = 8'h00;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         phase_ff     <= PH_A;
         line_ff      <= 7'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         line_ff  <= line_in;
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Command and output payload registers
   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
      if (emit) begin
         rsp_data_ff <= out_byte;
         rsp_last_ff <= step_done;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   a_line_cleared: assert property (@(posedge clock) disable iff (reset)
      (emit && state_ff == ST_LF) |=> (line_ff == 7'd0))
      else $error("line length not cleared after line end");

   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> (state_ff == ST_IDLE || step_done))
      else $error("command loaded while previous one still running");

   a_no_emit_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !step_done)
      else $error("transfer end flagged with nothing running");

endmodule

`default_nettype wire

// ===== sv/quoted_printable_encoder.sv =====
// Path: an item that yields output reaches rsp through the queue write at its transfer, then
// the command load into the emitter, then the output register; a busy emitter or a stalled rsp delays it.
// Throughput: one encoded byte per cycle while rsp_tready does not stall the output; an item
// yields up to 12 encoded bytes; an escaped byte yields 3 bytes.
// Reset: synchronous; drops any held byte, clears line length, queue and output valid, and
// loads the soft break length with 72.
`timescale 1ns / 1ps
`default_nettype none

module quoted_printable_encoder #(
   parameter int QueueDepth = qpe_pkg::QPE_QUEUE_DEPTH
) (
   input  wire        clock,
   input  wire        reset,
   input  wire        req_tvalid,
   output logic       req_tready,
   input  wire  [7:0] req_tdata,     // [7:0] in_byte
   input  wire        req_tlast,     // final_byte
   output logic       rsp_tvalid,
   input  wire        rsp_tready,
   output logic [7:0] rsp_tdata,     // [7:0] out_byte
   output logic       rsp_tlast,     // run_end
   input  wire        csr_wr_en,
   input  wire  [6:0] csr_wr_data    // soft_break_length
);
   import qpe_pkg::*;

   logic [6:0] limit_ff;
   logic       q_full;
   logic       q_push;
   logic       q_pop;
   logic       q_valid;
   cmd_type    q_cmd;
   cmd_type    q_head;

   // Soft break length register
   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= QPE_LIMIT_RESET;
      end else if (csr_wr_en) begin
         limit_ff <= csr_wr_data;
      end
   end

   qpe_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_cmd      (q_cmd)
   );

   qpe_fifo #(
      .Depth (QueueDepth)
   ) u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_cmd   (q_cmd),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_valid),
      .head_cmd   (q_head)
   );

   qpe_back u_back (
      .clock      (clock),
      .reset      (reset),
      .limit      (limit_ff),
      .q_valid    (q_valid),
      .q_head     (q_head),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

`default_nettype wire
